### rtl/core/qedc_pkg.sv
// Shared types and constants for the quad edge dominance check core.
// No dependencies; every other file in rtl/core except qedc_result_if imports this package.
package qedc_pkg;

  localparam int COORD_BITS_DEF     = 12;
  localparam int LEN_FRAC_BITS_DEF  = 8;
  localparam int TOP_EDGES_DEF      = 4;

  localparam int THR_W       = 16;
  localparam int RATIO_SHIFT = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd62259;  // about 0.95 in Q0.16

  localparam int PERIM_W = 31;
  localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};

  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] MIN_VERTICES = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_FEW  = 2'd1,
    VERDICT_ZERO = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_ADD,
    ST_CLOSE,
    ST_SUM,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;      // latch vertex, set up edge from previous vertex
    logic load_close;  // set up closing edge back to first vertex
    logic sq_x;
    logic sq_y;
    logic root_step;
    logic add_edge;
    logic sum_step;
    logic mul;
    logic finish;      // write result, clear polygon state
  } cmd_t;

  typedef struct packed {
    logic first_vertex;
    logic in_last;
    logic last;
    logic closing;
    logic root_done;
    logic sum_done;
    logic out_free;
  } status_t;

endpackage

### rtl/core/qedc_vertex_if.sv
// Vertex input channel: valid/ready handshake with one vertex per item.
// Depends on qedc_pkg for the default coordinate width.
interface qedc_vertex_if import qedc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex_x;
  logic [COORD_BITS-1:0] vertex_y;
  logic                  last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

### rtl/core/qedc_result_if.sv
// Result output channel: valid/ready handshake, one verdict per polygon.
// No package dependency.
interface qedc_result_if;
  logic       valid;
  logic       ready;
  logic       shape_ok;
  logic [1:0] verdict_code;

  modport source (output valid, output shape_ok, output verdict_code, input ready);
  modport sink   (input valid, input shape_ok, input verdict_code, output ready);
endinterface

### rtl/core/qedc_datapath.sv
// Datapath: polygon state, edge squarer, bit-serial square root, top-edge list,
// perimeter, threshold test and result register. Depends on qedc_pkg.
module qedc_datapath import qedc_pkg::*; #(
  parameter int COORD_BITS           = COORD_BITS_DEF,
  parameter int LENGTH_FRACTION_BITS = LEN_FRAC_BITS_DEF,
  parameter int TOP_EDGES            = TOP_EDGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [THR_W-1:0]      cfg_wdata,
  input  logic [COORD_BITS-1:0] vertex_x,
  input  logic [COORD_BITS-1:0] vertex_y,
  input  logic                  last_vertex,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  shape_ok,
  output logic [1:0]            verdict_code
);

  localparam int LEN_W  = COORD_BITS + 1 + LENGTH_FRACTION_BITS;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int RAD_W  = 2 * LEN_W;
  localparam int REM_W  = LEN_W + 2;
  localparam int IT_W   = $clog2(LEN_W);
  localparam int IDX_W  = $clog2(TOP_EDGES);
  localparam int TS_W   = LEN_W + IDX_W;
  localparam int PS_W   = ((PERIM_W > LEN_W) ? PERIM_W : LEN_W) + 1;
  localparam int PROD_W = PERIM_W + THR_W;
  localparam int LHS_W  = TS_W + RATIO_SHIFT;
  localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

  logic [THR_W-1:0]      thr;
  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [CNT_W-1:0]      count;
  logic                  last_r, closing;
  logic [2*COORD_BITS-1:0] acc;
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [LEN_W-1:0]      root;
  logic [IT_W-1:0]       iter;
  logic [LEN_W-1:0]      top [TOP_EDGES];
  logic [PERIM_W-1:0]    perim;
  logic [TS_W-1:0]       top_sum;
  logic [IDX_W-1:0]      sum_idx;
  logic [PROD_W-1:0]     prod;
  logic                  out_valid, out_ok;
  verdict_t              out_verdict;

  // edge arithmetic
  logic [COORD_BITS-1:0]   dx, dy, sq_op;
  logic [2*COORD_BITS-1:0] sq_prod;
  logic [SQ_W-1:0]         sq_sum;
  logic [REM_W-1:0]        rem_sh, trial;
  logic [TOP_EDGES-1:0]    gt;
  logic [LEN_W-1:0]        top_next [TOP_EDGES];
  logic [PS_W-1:0]         perim_sum;
  logic [PERIM_W-1:0]      perim_next;
  logic [CMP_W-1:0]        lhs, rhs;
  logic                    pass;

  always_comb begin
    dx      = (ax >= bx) ? (ax - bx) : (bx - ax);
    dy      = (ay >= by) ? (ay - by) : (by - ay);
    sq_op   = cmd.sq_x ? dx : dy;
    sq_prod = {{COORD_BITS{1'b0}}, sq_op} * {{COORD_BITS{1'b0}}, sq_op};
    sq_sum  = {1'b0, acc} + {1'b0, sq_prod};
    rem_sh  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial   = {root, 2'b01};
  end

  // list is descending, so gt is a run of zeros then ones
  always_comb begin
    for (int i = 0; i < TOP_EDGES; i++) begin
      gt[i] = root > top[i];
    end
    for (int i = 0; i < TOP_EDGES; i++) begin
      if (!gt[i]) begin
        top_next[i] = top[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        top_next[i] = top[(i > 0) ? i - 1 : 0];
      end else begin
        top_next[i] = root;
      end
    end
  end

  always_comb begin
    perim_sum  = PS_W'(perim) + PS_W'(root);
    perim_next = (perim_sum > PS_W'(PERIM_MAX)) ? PERIM_MAX : perim_sum[PERIM_W-1:0];
    lhs        = CMP_W'(top_sum) << RATIO_SHIFT;
    rhs        = CMP_W'(prod);
    pass       = lhs >= rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      count   <= '0;
      perim   <= '0;
      for (int i = 0; i < TOP_EDGES; i++) top[i] <= '0;
    end else if (cmd.finish) begin
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      count   <= '0;
      perim   <= '0;
      for (int i = 0; i < TOP_EDGES; i++) top[i] <= '0;
    end else begin
      if (cmd.accept) begin
        if (count == '0) begin
          first_x <= vertex_x;
          first_y <= vertex_y;
        end
        prev_x <= vertex_x;
        prev_y <= vertex_y;
        if (count < MIN_VERTICES) count <= count + CNT_W'(1);
      end
      if (cmd.add_edge) begin
        for (int i = 0; i < TOP_EDGES; i++) top[i] <= top_next[i];
        perim <= perim_next;
      end
    end
  end

  // edge setup, squaring and root iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      last_r  <= 1'b0;
      closing <= 1'b0;
    end else begin
      if (cmd.accept) begin
        last_r  <= last_vertex;
        closing <= 1'b0;
        ax <= (count == '0) ? vertex_x : prev_x;
        ay <= (count == '0) ? vertex_y : prev_y;
        bx <= vertex_x;
        by <= vertex_y;
      end
      if (cmd.load_close) begin
        closing <= 1'b1;
        ax <= prev_x;
        ay <= prev_y;
        bx <= first_x;
        by <= first_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      acc <= sq_prod;
    end
    if (cmd.sq_y) begin
      rad  <= RAD_W'(sq_sum) << (2 * LENGTH_FRACTION_BITS);
      rem  <= '0;
      root <= '0;
      iter <= IT_W'(LEN_W - 1);
    end else if (cmd.root_step) begin
      rad  <= rad << 2;
      iter <= iter - IT_W'(1);
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[LEN_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[LEN_W-2:0], 1'b0};
      end
    end
  end

  // evaluation
  always_ff @(posedge clk) begin
    if (cmd.load_close) begin
      top_sum <= '0;
      sum_idx <= '0;
    end else if (cmd.sum_step) begin
      top_sum <= top_sum + TS_W'(top[sum_idx]);
      sum_idx <= sum_idx + IDX_W'(1);
    end
    if (cmd.mul) begin
      prod <= PROD_W'(thr) * PROD_W'(perim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (res_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      priority if (count < MIN_VERTICES) begin
        out_ok      <= 1'b0;
        out_verdict <= VERDICT_FEW;
      end else if (perim == '0) begin
        out_ok      <= 1'b0;
        out_verdict <= VERDICT_ZERO;
      end else begin
        out_ok      <= pass;
        out_verdict <= VERDICT_OK;
      end
    end
  end

  always_comb begin
    status.first_vertex = (count == '0);
    status.in_last      = last_vertex;
    status.last         = last_r;
    status.closing      = closing;
    status.root_done    = (iter == '0);
    status.sum_done     = (sum_idx == IDX_W'(TOP_EDGES - 1));
    status.out_free     = !out_valid || res_ready;
  end

  assign res_valid    = out_valid;
  assign shape_ok     = out_ok;
  assign verdict_code = out_verdict;

endmodule

### rtl/core/qedc_ctrl.sv
// Sequencer for the edge dominance check: steps the datapath through
// square, root, insert and evaluation. Depends on qedc_pkg.
module qedc_ctrl import qedc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.first_vertex) begin
            state_next = ST_SQ_X;
          end else if (status.in_last) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_SQ_X: begin
        cmd.sq_x   = 1'b1;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.sq_y   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_edge = 1'b1;
        priority if (status.last && !status.closing) begin
          state_next = ST_CLOSE;
        end else if (status.last) begin
          state_next = ST_SUM;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        cmd.load_close = 1'b1;
        state_next     = ST_SQ_X;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register can take the verdict
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/quad_edge_dominance_check_core.sv
// Channel    Dir  Item
// vertex     in   vertex_x, vertex_y, last_vertex (one polygon vertex)
// result     out  shape_ok, verdict_code (one per polygon, on its last vertex)
// cfg_we/wd  in   ratio_threshold, Q0.16
//
// A vertex's time is set by the square root, which retires one bit per cycle
// over LEN_W = COORD_BITS + 1 + LENGTH_FRACTION_BITS result bits.
// The last vertex adds the closing edge, then summing of the top edges,
// multiply and compare. A first vertex that is not the last gets no edge length.
// Synchronous reset restores the threshold and clears polygon state at once.
// A result waits in the output register; vertices of the next polygon keep
// coming in, and only its own verdict waits for the register to empty.
// Top level; depends on qedc_pkg, qedc_vertex_if, qedc_result_if,
// qedc_ctrl and qedc_datapath.
module quad_edge_dominance_check_core import qedc_pkg::*; #(
  parameter int COORD_BITS           = COORD_BITS_DEF,
  parameter int LENGTH_FRACTION_BITS = LEN_FRAC_BITS_DEF,
  parameter int TOP_EDGES            = TOP_EDGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  qedc_vertex_if.sink      vertex,
  qedc_result_if.source    result,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign vertex.ready = in_ready;

  qedc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertex.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qedc_datapath #(
    .COORD_BITS           (COORD_BITS),
    .LENGTH_FRACTION_BITS (LENGTH_FRACTION_BITS),
    .TOP_EDGES            (TOP_EDGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .vertex_x     (vertex.vertex_x),
    .vertex_y     (vertex.vertex_y),
    .last_vertex  (vertex.last_vertex),
    .cmd          (cmd),
    .status       (status),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .shape_ok     (result.shape_ok),
    .verdict_code (result.verdict_code)
  );

endmodule

### rtl/core/qedc_checker.sv
// Port-level checks for quad_edge_dominance_check_core, bound to the top.
// Depends on qedc_pkg for verdict codes.
module qedc_checker import qedc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       shape_ok,
  input logic [1:0] verdict_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(shape_ok) && $stable(verdict_code))
    else $error("result payload changed while stalled");

  a_ok_evaluated: assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_ok |-> verdict_code == VERDICT_OK)
    else $error("shape_ok set on a rejected polygon");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict_code == VERDICT_OK || verdict_code == VERDICT_FEW ||
                  verdict_code == VERDICT_ZERO)
    else $error("undefined verdict code");

  // closing edge and evaluation always follow the last vertex
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("vertex taken right after a last vertex");

endmodule

bind quad_edge_dominance_check_core qedc_checker u_qedc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (vertex.valid),
  .in_ready     (vertex.ready),
  .in_last      (vertex.last_vertex),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .shape_ok     (result.shape_ok),
  .verdict_code (result.verdict_code)
);

### tb/quad_edge_dominance_check_core_test.sv
// Self-checking testbench for quad_edge_dominance_check_core: polygons in, verdicts out.
// Depends on qedc_pkg, qedc_vertex_if, qedc_result_if and the core RTL.
// Directed table first, then random polygons and a zigzag polygon, checked by an in-bench predictor.
`timescale 1ns / 100ps

module quad_edge_dominance_check_core_test import qedc_pkg::*; ();

  localparam int COORD_MAX = (1 << COORD_BITS_DEF) - 1;
  localparam int LEN_MSB   = COORD_BITS_DEF + LEN_FRAC_BITS_DEF;  // length is LEN_MSB+1 bits
  localparam int DRAIN_CYCLES = 4 * (LEN_MSB + 5) + TOP_EDGES_DEF;

  typedef struct packed {
    logic [COORD_BITS_DEF-1:0] x;
    logic [COORD_BITS_DEF-1:0] y;
    logic                      last;
    logic                      typed;  // expected verdict given in the row
    logic                      ok;
    verdict_t                  code;
  } vertex_row_t;

  typedef struct packed {
    logic     ok;
    verdict_t code;
  } verdict_item_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [THR_W-1:0]       cfg_wdata;
  bit                     steady;  // both sides run without idling
  int                     mismatches;
  verdict_item_t          pending_verdicts[$];

  // predictor state
  logic [THR_W-1:0]          ratio_thr;
  logic [COORD_BITS_DEF-1:0] poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
  logic [CNT_W-1:0]          poly_vertices;
  logic [LEN_MSB:0]          top_lengths[TOP_EDGES_DEF];
  logic [PERIM_W-1:0]        perimeter;

  qedc_vertex_if vertex_ch ();
  qedc_result_if result_ch ();

  quad_edge_dominance_check_core dut (
    .clk      (clk),
    .rst      (rst),
    .vertex   (vertex_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  vertex_row_t directed_rows [24] = '{
    // lone vertex, two vertices, three vertices: too few
    '{12'd0,    12'd0,    1'b1, 1'b1, 1'b0, VERDICT_FEW},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd0,    12'd0,    1'b1, 1'b1, 1'b0, VERDICT_FEW},
    '{12'd4095, 12'd0,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd0,    12'd4095, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0, VERDICT_FEW},
    // four identical points: zero perimeter
    '{12'd7,    12'd7,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd7,    12'd7,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd7,    12'd7,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd7,    12'd7,    1'b1, 1'b1, 1'b0, VERDICT_ZERO},
    // full-range square: the top-edge list holds every edge, so it is the whole perimeter
    '{12'd0,    12'd0,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4095, 12'd0,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd0,    12'd4095, 1'b1, 1'b1, 1'b1, VERDICT_OK},
    // pentagon with a split side: short of the threshold
    '{12'd0,    12'd0,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4095, 12'd0,    1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd0,    12'd4095, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd0,    12'd2048, 1'b1, 1'b0, 1'b0, VERDICT_OK},
    // pentagon with one tiny edge: above the threshold
    '{12'd100,  12'd100,  1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4000, 12'd100,  1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd4000, 12'd4000, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd100,  12'd4000, 1'b0, 1'b0, 1'b0, VERDICT_OK},
    '{12'd100,  12'd3990, 1'b1, 1'b0, 1'b0, VERDICT_OK}
  };

  task automatic report_mismatch(input string msg);
    $display("%0t verdict mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // floor(sqrt(dist^2 * 4^frac)), bit by bit from the top
  function automatic logic [LEN_MSB:0] edge_len(input logic [COORD_BITS_DEF-1:0] ax, ay, bx, by);
    longint unsigned dx, dy, scaled, root, cand;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    scaled = (dx * dx + dy * dy) << (2 * LEN_FRAC_BITS_DEF);
    root = 0;
    for (int b = LEN_MSB; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= scaled)
        root = cand;
    end
    return root[LEN_MSB:0];
  endfunction

  task automatic clear_polygon();
    poly_first_x = '0;
    poly_first_y = '0;
    poly_prev_x = '0;
    poly_prev_y = '0;
    poly_vertices = '0;
    foreach (top_lengths[i]) top_lengths[i] = '0;
    perimeter = '0;
  endtask

  task automatic insert_edge(input logic [LEN_MSB:0] len);
    int slot;
    longint unsigned grown;
    slot = TOP_EDGES_DEF;
    for (int i = TOP_EDGES_DEF - 1; i >= 0; i--)
      if (len > top_lengths[i]) slot = i;
    if (slot < TOP_EDGES_DEF) begin
      for (int i = TOP_EDGES_DEF - 1; i > slot; i--)
        top_lengths[i] = top_lengths[i-1];
      top_lengths[slot] = len;
    end
    grown = longint'(perimeter) + len;
    perimeter = (grown > PERIM_MAX) ? PERIM_MAX : grown[PERIM_W-1:0];
  endtask

  task automatic predict_vertex(input logic [COORD_BITS_DEF-1:0] x, y, input logic last,
                                output bit fires, output verdict_item_t verdict);
    longint unsigned top_sum;
    fires = 1'b0;
    verdict = '{1'b0, VERDICT_OK};
    if (poly_vertices == 0) begin
      poly_first_x = x;
      poly_first_y = y;
    end else begin
      insert_edge(edge_len(poly_prev_x, poly_prev_y, x, y));
    end
    if (poly_vertices < MIN_VERTICES)
      poly_vertices++;
    poly_prev_x = x;
    poly_prev_y = y;
    if (last) begin
      fires = 1'b1;
      insert_edge(edge_len(x, y, poly_first_x, poly_first_y));
      if (poly_vertices < MIN_VERTICES) begin
        verdict.code = VERDICT_FEW;
      end else if (perimeter == 0) begin
        verdict.code = VERDICT_ZERO;
      end else begin
        top_sum = 0;
        foreach (top_lengths[i]) top_sum += top_lengths[i];
        verdict.ok = ((top_sum << RATIO_SHIFT) >= longint'(ratio_thr) * perimeter);
      end
      clear_polygon();
    end
  endtask

  // valid stays high after an item; the next call either idles or drives the next one
  task automatic send_vertex(input logic [COORD_BITS_DEF-1:0] x, y, input logic last,
                             input bit typed, input verdict_item_t typed_verdict);
    bit fires;
    verdict_item_t verdict;
    while (!steady && $urandom_range(99) < 26) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid       <= 1'b1;
    vertex_ch.vertex_x    <= x;
    vertex_ch.vertex_y    <= y;
    vertex_ch.last_vertex <= last;
    @(posedge clk);
    while (!vertex_ch.ready) @(posedge clk);
    predict_vertex(x, y, last, fires, verdict);
    if (fires)
      pending_verdicts.push_back(typed ? typed_verdict : verdict);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] value);
    vertex_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ratio_thr = value;
  endtask

  function automatic logic [COORD_BITS_DEF-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS_DEF'(COORD_MAX);
    return v[COORD_BITS_DEF-1:0];
  endfunction

  // Mostly near-quadrilaterals (four random corners with small detours), so the
  // ratio lands close to the threshold; the rest are short, flat or noisy.
  task automatic send_random_polygon(output int sent);
    int unsigned kind, spread, extras;
    int px, py;
    logic [COORD_BITS_DEF-1:0] xs[$], ys[$];
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 3)) begin
        xs.push_back(COORD_BITS_DEF'($urandom_range(COORD_MAX)));
        ys.push_back(COORD_BITS_DEF'($urandom_range(COORD_MAX)));
      end
    end else if (kind < 15) begin
      px = $urandom_range(COORD_MAX);
      py = $urandom_range(COORD_MAX);
      repeat ($urandom_range(4, 7)) begin
        xs.push_back(COORD_BITS_DEF'(px));
        ys.push_back(COORD_BITS_DEF'(py));
      end
    end else if (kind < 30) begin
      repeat ($urandom_range(4, 12)) begin
        xs.push_back(COORD_BITS_DEF'($urandom_range(COORD_MAX)));
        ys.push_back(COORD_BITS_DEF'($urandom_range(COORD_MAX)));
      end
    end else begin
      spread = 1 << $urandom_range(1, 10);
      repeat (4) begin
        px = $urandom_range(COORD_MAX);
        py = $urandom_range(COORD_MAX);
        xs.push_back(COORD_BITS_DEF'(px));
        ys.push_back(COORD_BITS_DEF'(py));
        extras = $urandom_range(2);
        repeat (extras) begin
          xs.push_back(clamp_coord(px + int'($urandom_range(spread)) - int'(spread / 2)));
          ys.push_back(clamp_coord(py + int'($urandom_range(spread)) - int'(spread / 2)));
        end
      end
    end
    foreach (xs[i])
      send_vertex(xs[i], ys[i], i == xs.size() - 1, 1'b0, '{1'b0, VERDICT_OK});
    sent = xs.size();
  endtask

  task automatic run_random_polygons(input int target);
    int sent, total;
    total = 0;
    while (total < target) begin
      send_random_polygon(sent);
      total += sent;
    end
  endtask

  always @(posedge clk) begin : verdict_monitor
    verdict_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict ok=%0b code=%0d",
                                  result_ch.shape_ok, result_ch.verdict_code));
      end else begin
        want = pending_verdicts.pop_front();
        if (result_ch.shape_ok !== want.ok)
          report_mismatch($sformatf("shape_ok %0b, want %0b", result_ch.shape_ok, want.ok));
        if (result_ch.verdict_code !== want.code)
          report_mismatch($sformatf("verdict_code %0d, want %0d",
                                    result_ch.verdict_code, want.code));
      end
    end
    result_ch.ready <= steady || ($urandom_range(99) >= 26);
  end

  initial begin
    #10_000_000;
    $display("quad_edge_dominance_check_core regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    vertex_ch.valid = 1'b0;
    vertex_ch.vertex_x = '0;
    vertex_ch.vertex_y = '0;
    vertex_ch.last_vertex = 1'b0;
    result_ch.ready = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    ratio_thr = THR_RESET;
    clear_polygon();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                  directed_rows[i].typed, '{directed_rows[i].ok, directed_rows[i].code});

    set_threshold('1);
    run_random_polygons(130);
    set_threshold('0);
    run_random_polygons(90);
    set_threshold(THR_W'($urandom_range(65535)));
    run_random_polygons(80);
    set_threshold(THR_W'($urandom_range(58000, 65535)));
    steady = 1'b1;
    run_random_polygons(80);
    steady = 1'b0;

    // zigzag between opposite corners: many equal diagonal edges
    set_threshold(16'd181);
    for (int i = 0; i < 64; i++)
      send_vertex((i % 2) ? COORD_BITS_DEF'(COORD_MAX) : '0,
                  (i % 2) ? COORD_BITS_DEF'(COORD_MAX) : '0, i == 63,
                  1'b0, '{1'b0, VERDICT_OK});

    set_threshold(THR_RESET);
    run_random_polygons(130);

    vertex_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("quad_edge_dominance_check_core regression: pass");
    else
      $display("quad_edge_dominance_check_core regression: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/qedc_pkg.sv
rtl/core/qedc_vertex_if.sv
rtl/core/qedc_result_if.sv
rtl/core/qedc_datapath.sv
rtl/core/qedc_ctrl.sv
rtl/core/quad_edge_dominance_check_core.sv
rtl/core/qedc_checker.sv
tb/quad_edge_dominance_check_core_test.sv
